[hw/rtl/polygon_region_raster_fill_top_assert.svh]
// assertion macros shared by the fill block
`ifndef POLYGON_REGION_RASTER_FILL_TOP_ASSERT_SVH
`define POLYGON_REGION_RASTER_FILL_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define PRFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PRFT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRFT_ASSERT_IMP(lbl, ante, cons)
`define PRFT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/prft_pkg.sv]
package prft_pkg;

  // field widths fixed by the item format
  localparam int CFG_W   = 9;
  localparam int LABEL_W = 9;
  localparam int COORD_W = 16;
  localparam int CRD_W   = 18;

  localparam logic [LABEL_W-1:0] LABEL_NONE = 9'h1FF;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_VERTEX = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SWEEP,
    OP_MIN_RD,
    OP_MIN_CMP,
    OP_EDGE_RA,
    OP_EDGE_RB,
    OP_EDGE_SET,
    OP_ROW_NEXT,
    OP_MUL,
    OP_CELL_RD,
    OP_CELL_WR,
    OP_EDGE_NEXT,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic sweep_empty;
    logic min_last;
    logic edge_last;
    logic row_end;
    logic row_hit;
    logic cell_go;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/prft_ctrl.sv]
module prft_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_kind,
  input  logic             in_last,
  output logic             in_ready,
  input  prft_pkg::status_t status,
  output prft_pkg::cmd_t    cmd
);
  import prft_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_RDW, S_MIN_RD, S_MIN_CMP,
    S_EDGE_A, S_EDGE_B, S_EDGE_SET, S_ROW, S_CELL, S_CELL_WR
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_INIT: begin
        cmd.op = OP_SWEEP;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          case (in_kind)
            KIND_CLEAR:  state_next = S_CLR;
            KIND_VERTEX: state_next = in_last ? S_MIN_RD : S_IDLE;
            KIND_READ:   state_next = S_RDW;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        if (status.sweep_empty) begin
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_SWEEP;
          if (status.sweep_last) state_next = S_IDLE;
        end
      end
      S_RDW: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      S_MIN_RD: begin
        cmd.op     = OP_MIN_RD;
        state_next = S_MIN_CMP;
      end
      S_MIN_CMP: begin
        cmd.op     = OP_MIN_CMP;
        state_next = status.min_last ? S_EDGE_A : S_MIN_RD;
      end
      S_EDGE_A: begin
        cmd.op     = OP_EDGE_RA;
        state_next = S_EDGE_B;
      end
      S_EDGE_B: begin
        cmd.op     = OP_EDGE_RB;
        state_next = S_EDGE_SET;
      end
      S_EDGE_SET: begin
        cmd.op     = OP_EDGE_SET;
        state_next = S_ROW;
      end
      S_ROW: begin
        if (status.row_end) begin
          cmd.op     = OP_EDGE_NEXT;
          state_next = status.edge_last ? S_IDLE : S_EDGE_A;
        end else if (status.row_hit) begin
          cmd.op     = OP_MUL;
          state_next = S_CELL;
        end else begin
          cmd.op = OP_ROW_NEXT;
        end
      end
      S_CELL: begin
        if (status.cell_go) begin
          cmd.op     = OP_CELL_RD;
          state_next = S_CELL_WR;
        end else begin
          cmd.op     = OP_ROW_NEXT;
          state_next = S_ROW;
        end
      end
      S_CELL_WR: begin
        cmd.op     = OP_CELL_WR;
        state_next = S_CELL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

endmodule

[hw/rtl/prft_datapath.sv]
`include "polygon_region_raster_fill_top_assert.svh"

module prft_datapath #(
  parameter int GRID_SIDE    = 256,
  parameter int MAX_VERTICES = 256,
  parameter int MAX_REGIONS  = 256,
  parameter int FRAC_BITS    = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  prft_pkg::cmd_t                cmd,
  output prft_pkg::status_t             status,
  input  logic [1:0]                    in_kind,
  input  logic [7:0]                    in_region,
  input  logic [prft_pkg::COORD_W-1:0]  in_x,
  input  logic [prft_pkg::COORD_W-1:0]  in_y,
  input  logic [7:0]                    in_col,
  input  logic [7:0]                    in_row,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [prft_pkg::CFG_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prft_pkg::LABEL_W-1:0]  out_label
);
  import prft_pkg::*;

  localparam int GIW = $clog2(GRID_SIDE);
  localparam int AW  = 2 * GIW;
  localparam int SW  = $clog2(GRID_SIDE + 1);
  localparam int ZW  = (SW > CFG_W) ? SW : CFG_W;
  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int YB  = GIW + FRAC_BITS + 1;
  localparam int LW  = ((YB > CRD_W - 1) ? YB : CRD_W - 1) + 2;
  localparam int DW  = CRD_W + 1;
  localparam int PW  = LW + DW;
  localparam int MW  = (SW > COORD_W) ? SW : COORD_W;

  // coordinate minus one half, doubled
  function automatic logic signed [CRD_W-1:0] cen(input logic [COORD_W-1:0] raw);
    cen = $signed({1'b0, raw, 1'b0}) - $signed(CRD_W'(1) << FRAC_BITS);
  endfunction

  // configuration and persistent state
  logic [CFG_W-1:0]   gw, gh;
  logic [VCW-1:0]     vcount;
  logic [COORD_W-1:0] least_x;
  logic [7:0]         cur_region;
  logic               fill_last;

  // sweep and loop counters
  logic [SW-1:0]  lim_w, lim_h, sc, sr, l;
  logic [VCW-1:0] kc, k, prv;
  logic [MW-1:0]  m;

  // edge and crossing registers
  logic [31:0]             va;
  logic signed [CRD_W-1:0] xb, yb, ylo, yhi;
  logic signed [DW-1:0]    den, dx;
  logic signed [PW-1:0]    num, lhs;
  logic                    rd_in;

  // memories
  logic [LABEL_W-1:0] gmem [GRID_SIDE*GRID_SIDE];
  logic [31:0]        vmem [MAX_VERTICES];
  logic [LABEL_W-1:0] gq;
  logic [31:0]        vq;

  logic [SW-1:0] eff_w, eff_h;
  assign eff_w = (ZW'(gw) > ZW'(GRID_SIDE)) ? SW'(GRID_SIDE) : SW'(gw);
  assign eff_h = (ZW'(gh) > ZW'(GRID_SIDE)) ? SW'(GRID_SIDE) : SW'(gh);

  logic [7:0] reg_sat;
  assign reg_sat = (32'(in_region) >= MAX_REGIONS) ? 8'(MAX_REGIONS - 1) : in_region;

  logic accept_vtx;
  assign accept_vtx = (cmd.op == OP_ACCEPT) && (in_kind == KIND_VERTEX);

  // edge setup arithmetic
  logic signed [CRD_W-1:0] xa_c, ya_c, xb_c, yb_c;
  logic signed [DW-1:0]    dy_c, dx_c;
  assign xa_c = cen(va[15:0]);
  assign ya_c = cen(va[31:16]);
  assign xb_c = cen(vq[15:0]);
  assign yb_c = cen(vq[31:16]);
  assign dy_c = DW'(ya_c) - DW'(yb_c);
  assign dx_c = DW'(xa_c) - DW'(xb_c);

  // row and column terms
  logic [COORD_W-1:0]   first;
  logic signed [LW-1:0] yl, mu, yb_x, xb_x, ylo_x, yhi_x;
  logic signed [PW-1:0] inc;
  assign first = least_x >> FRAC_BITS;
  assign yl    = LW'(l) << (FRAC_BITS + 1);
  assign mu    = LW'(first) << (FRAC_BITS + 1);
  assign yb_x  = LW'(yb);
  assign xb_x  = LW'(xb);
  assign ylo_x = LW'(ylo);
  assign yhi_x = LW'(yhi);
  assign inc   = PW'(den) <<< (FRAC_BITS + 1);

  // status toward the controller
  assign status.sweep_last  = (sr == lim_h - SW'(1)) && (sc == lim_w - SW'(1));
  assign status.sweep_empty = (lim_w == '0) || (lim_h == '0);
  assign status.min_last    = (kc == vcount - VCW'(1));
  assign status.edge_last   = (k == vcount - VCW'(1));
  assign status.row_end     = (den == '0) || (l >= eff_h);
  assign status.row_hit     = (yl >= ylo_x) && (yl < yhi_x);
  assign status.cell_go     = (m < MW'(eff_w)) && (lhs < num);
  assign status.out_free    = !out_valid || out_ready;

  // grid port selection
  logic               g_we;
  logic [AW-1:0]      g_wa, g_ra;
  logic [LABEL_W-1:0] g_wd;
  always_comb begin
    g_we = 1'b0;
    g_wa = {GIW'(sc), GIW'(sr)};
    g_wd = LABEL_NONE;
    g_ra = {GIW'(m), GIW'(l)};
    case (cmd.op)
      OP_SWEEP: g_we = 1'b1;
      OP_CELL_WR: begin
        g_we = 1'b1;
        g_wa = {GIW'(m), GIW'(l)};
        g_wd = {1'b0, cur_region} - gq - LABEL_W'(1);
      end
      OP_ACCEPT: g_ra = {GIW'(in_col), GIW'(in_row)};
      default: g_we = 1'b0;
    endcase
  end

  // label grid, read data held until the next read
  always_ff @(posedge clk) begin
    if (g_we) gmem[g_wa] <= g_wd;
    if ((cmd.op == OP_ACCEPT) || (cmd.op == OP_CELL_RD)) gq <= gmem[g_ra];
  end

  // vertex store port selection
  logic [VIW-1:0] v_ra;
  always_comb begin
    case (cmd.op)
      OP_EDGE_RA: v_ra = k[VIW-1:0];
      OP_EDGE_RB: v_ra = prv[VIW-1:0];
      default:    v_ra = kc[VIW-1:0];
    endcase
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (accept_vtx && (vcount < VCW'(MAX_VERTICES)))
      vmem[vcount[VIW-1:0]] <= {in_y, in_x};
    vq <= vmem[v_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      gw         <= CFG_W'(256);
      gh         <= CFG_W'(256);
      vcount     <= '0;
      least_x    <= '0;
      cur_region <= '0;
      fill_last  <= 1'b0;
      lim_w      <= SW'(GRID_SIDE);
      lim_h      <= SW'(GRID_SIDE);
      sc         <= '0;
      sr         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRID_WIDTH) gw <= cfg_data;
        else                             gh <= cfg_data;
      end
      if (cmd.op == OP_OUT_LOAD) out_valid <= 1'b1;
      else if (out_ready)        out_valid <= 1'b0;
      case (cmd.op)
        OP_ACCEPT: begin
          if (in_kind == KIND_CLEAR) begin
            lim_w <= eff_w;
            lim_h <= eff_h;
            sc    <= '0;
            sr    <= '0;
          end
          if (accept_vtx) begin
            cur_region <= reg_sat;
            fill_last  <= 1'b1;
            if (vcount < VCW'(MAX_VERTICES)) vcount <= vcount + VCW'(1);
          end
        end
        OP_SWEEP: begin
          if (sr == lim_h - SW'(1)) begin
            sr <= '0;
            sc <= sc + SW'(1);
          end else begin
            sr <= sr + SW'(1);
          end
        end
        OP_MIN_CMP: begin
          if ((kc == '0) || (vq[15:0] < least_x)) least_x <= vq[15:0];
        end
        OP_EDGE_NEXT: begin
          if (status.edge_last) vcount <= '0;
        end
        default: fill_last <= fill_last;
      endcase
    end
  end

  // loop counters and crossing datapath
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        kc    <= '0;
        rd_in <= (ZW'(in_col) < ZW'(eff_w)) && (ZW'(in_row) < ZW'(eff_h));
      end
      OP_MIN_CMP: begin
        kc <= kc + VCW'(1);
        if (status.min_last) begin
          k   <= '0;
          prv <= vcount - VCW'(1);
        end
      end
      OP_EDGE_RB: va <= vq;
      OP_EDGE_SET: begin
        xb  <= xb_c;
        yb  <= yb_c;
        ylo <= (ya_c < yb_c) ? ya_c : yb_c;
        yhi <= (ya_c < yb_c) ? yb_c : ya_c;
        den <= (dy_c < 0) ? -dy_c : dy_c;
        dx  <= (dy_c < 0) ? -dx_c : dx_c;
        l   <= '0;
      end
      OP_ROW_NEXT: l <= l + SW'(1);
      OP_MUL: begin
        num <= dx * (yl - yb_x);
        lhs <= (mu - xb_x) * den;
        m   <= MW'(first);
      end
      OP_CELL_WR: begin
        lhs <= lhs + inc;
        m   <= m + MW'(1);
      end
      OP_EDGE_NEXT: begin
        prv <= k;
        k   <= k + VCW'(1);
      end
      OP_OUT_LOAD: out_label <= rd_in ? gq : LABEL_NONE;
      default: m <= m;
    endcase
  end

  `PRFT_ASSERT_IMP(a_cell_in_grid, cmd.op == OP_CELL_WR, (m < MW'(eff_w)) && (l < eff_h))
  `PRFT_ASSERT_IMP(a_vcount_max, fill_last || !fill_last, vcount <= VCW'(MAX_VERTICES))
  `PRFT_ASSERT_IMP(a_out_no_overwrite, cmd.op == OP_OUT_LOAD, !out_valid || out_ready)

endmodule

[hw/rtl/polygon_region_raster_fill_top.sv]
// Even-odd scanline polygon fill into a grid of signed 9-bit region labels.
// After reset a clearing pass writes -1 into all GRID_SIDE*GRID_SIDE cells,
// one cell a cycle, and no item is taken until it ends; register writes are
// taken throughout. A clear item sweeps the cells in use. The last vertex
// starts the fill: a least-x scan over the stored vertices, then per edge a
// setup that reads both end vertices and loads the edge registers and a step
// to close it (a horizontal edge takes only these), a step per grid row in
// use, one more per row the edge crosses, and a read and a write per toggled
// cell. A read item reads the cell's label when it is accepted and gives its
// beat once the output is free. One item is worked at a time.
module polygon_region_raster_fill_top #(
  parameter int GRID_SIDE    = 256,
  parameter int MAX_VERTICES = 256,
  parameter int MAX_REGIONS  = 256,
  parameter int FRAC_BITS    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // region[7:0], vertex_x[23:8], vertex_y[39:24], cell_col[47:40], cell_row[55:48]
  input  logic [55:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  // last_vertex
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cell_label[8:0], zero fill above
  output logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import prft_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [LABEL_W-1:0] label;

  prft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  prft_datapath #(
    .GRID_SIDE    (GRID_SIDE),
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_REGIONS  (MAX_REGIONS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_kind   (s_tuser),
    .in_region (s_tdata[7:0]),
    .in_x      (s_tdata[23:8]),
    .in_y      (s_tdata[39:24]),
    .in_col    (s_tdata[47:40]),
    .in_row    (s_tdata[55:48]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_label (label)
  );

  assign m_tdata = {7'd0, label};

endmodule
